// File: hw/rtl/bdop_pkg.sv
package bdop_pkg;

   // request codes
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
   localparam logic [2:0] REQ_POP_BACK   = 3'd2;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
   localparam logic [2:0] REQ_SHUTDOWN   = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_DONE        = 2'd0;
   localparam logic [1:0] STATUS_WOULD_BLOCK = 2'd1;
   localparam logic [1:0] STATUS_FAILED      = 2'd2;

   // full-queue push policies
   localparam logic [1:0] POLICY_WAIT        = 2'd0;
   localparam logic [1:0] POLICY_DROP_NEWEST = 2'd1;
   localparam logic [1:0] POLICY_DROP_OLDEST = 2'd2;
   localparam logic [1:0] POLICY_FAIL        = 2'd3;

   // CSR map
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERFLOW_MODE  = 2'd1;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] push_value;
      logic [1:0]  close_mask;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] pop_value;
      logic        drop_valid;
      logic [31:0] drop_value;
      logic [4:0]  occupancy;
   } rsp_item_type;

   // what the control unit decided for a transaction, carried through the read stage
   typedef struct packed {
      logic [1:0] status;
      logic       pop_hit;
      logic       drop_hit;
      logic [4:0] occupancy;
   } issue_info_type;

endpackage

// File: hw/rtl/bdop_ram.sv
module bdop_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write of the same entry in one cycle returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bdop_ctrl.sv
module bdop_ctrl #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  bdop_pkg::req_item_type                   req_item,
   input  logic                                     csr_write,
   input  logic [bdop_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [bdop_pkg::CSR_DATA_W-1:0]          csr_wdata,
   output logic                                     ram_wr_en,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_wr_addr,
   output logic [DATA_WIDTH-1:0]                    ram_wr_data,
   output logic                                     ram_rd_en,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_rd_addr,
   output bdop_pkg::issue_info_type                 issue_info
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int KW = (CW > 5) ? CW : 5;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          enq_closed_ff, enq_closed_in;
   logic          deq_closed_ff, deq_closed_in;
   logic [4:0]    cap_ff, cap_in;
   logic [1:0]    policy_ff, policy_in;

   logic [KW-1:0] cap_ext, eff_cap;
   logic          full, back, evict_back;
   logic [SW-1:0] end_sum, back_sum;
   logic [AW-1:0] slot_end, slot_back, front_inc, front_dec;
   logic [1:0]    status;
   logic          pop_hit, drop_hit, rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [AW-1:0] nx_front;
   logic [CW-1:0] nx_cnt;
   logic          nx_enq_closed, nx_deq_closed;

   function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
      logic [SW-1:0] red;
      red = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
      return AW'(red);
   endfunction

   // clamp capacity into 1..DEPTH
   always_comb begin
      cap_ext = KW'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = KW'(1);
      end else if (cap_ext > KW'(DEPTH)) begin
         eff_cap = KW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full      = KW'(cnt_ff) >= eff_cap;
   assign end_sum   = SW'(front_ff) + SW'(cnt_ff);
   assign back_sum  = end_sum - SW'(1);
   assign slot_end  = wrap_slot(end_sum);
   assign slot_back = wrap_slot(back_sum);
   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + AW'(1);
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - AW'(1);
   assign back      = (req_item.req_type == bdop_pkg::REQ_PUSH_BACK);
   assign evict_back = (policy_ff == bdop_pkg::POLICY_DROP_NEWEST) ? back : !back;

   always_comb begin
      status        = bdop_pkg::STATUS_DONE;
      pop_hit       = 1'b0;
      drop_hit      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_end;
      nx_front      = front_ff;
      nx_cnt        = cnt_ff;
      nx_enq_closed = enq_closed_ff;
      nx_deq_closed = deq_closed_ff;
      unique case (req_item.req_type) inside
         bdop_pkg::REQ_PUSH_BACK, bdop_pkg::REQ_PUSH_FRONT: begin
            if (enq_closed_ff) begin
               status = bdop_pkg::STATUS_FAILED;
            end else if (full && policy_ff == bdop_pkg::POLICY_WAIT) begin
               status = bdop_pkg::STATUS_WOULD_BLOCK;
            end else if (full && policy_ff == bdop_pkg::POLICY_FAIL) begin
               status = bdop_pkg::STATUS_FAILED;
            end else begin
               wr_en  = 1'b1;
               nx_cnt = full ? cnt_ff : cnt_ff + CW'(1);
               if (full) begin
                  // evict one end; the freed slot may be rewritten this cycle
                  drop_hit = 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = evict_back ? slot_back : front_ff;
               end
               if (back) begin
                  wr_addr  = (full && evict_back) ? slot_back : slot_end;
                  nx_front = (full && !evict_back) ? front_inc : front_ff;
               end else begin
                  wr_addr  = (full && !evict_back) ? front_ff : front_dec;
                  nx_front = wr_addr;
               end
            end
         end
         bdop_pkg::REQ_POP_BACK, bdop_pkg::REQ_POP_FRONT: begin
            if (cnt_ff == '0) begin
               status = deq_closed_ff ? bdop_pkg::STATUS_FAILED
                                      : bdop_pkg::STATUS_WOULD_BLOCK;
            end else begin
               pop_hit = 1'b1;
               rd_en   = 1'b1;
               nx_cnt  = cnt_ff - CW'(1);
               if (req_item.req_type == bdop_pkg::REQ_POP_BACK) begin
                  rd_addr = slot_back;
               end else begin
                  rd_addr  = front_ff;
                  nx_front = front_inc;
               end
            end
         end
         bdop_pkg::REQ_SHUTDOWN: begin
            nx_enq_closed = enq_closed_ff | req_item.close_mask[0];
            nx_deq_closed = deq_closed_ff | req_item.close_mask[1];
         end
         default: begin
            status = bdop_pkg::STATUS_FAILED;
         end
      endcase
   end

   always_comb begin
      front_in      = accept ? nx_front : front_ff;
      cnt_in        = accept ? nx_cnt : cnt_ff;
      enq_closed_in = accept ? nx_enq_closed : enq_closed_ff;
      deq_closed_in = accept ? nx_deq_closed : deq_closed_ff;
      cap_in        = cap_ff;
      policy_in     = policy_ff;
      if (csr_write) begin
         unique case (csr_index)
            bdop_pkg::CSR_CAPACITY_LIMIT: cap_in    = csr_wdata[4:0];
            bdop_pkg::CSR_OVERFLOW_MODE:  policy_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         cnt_ff        <= '0;
         enq_closed_ff <= 1'b0;
         deq_closed_ff <= 1'b0;
         cap_ff        <= bdop_pkg::CAPACITY_RESET;
         policy_ff     <= bdop_pkg::POLICY_WAIT;
      end else begin
         front_ff      <= front_in;
         cnt_ff        <= cnt_in;
         enq_closed_ff <= enq_closed_in;
         deq_closed_ff <= deq_closed_in;
         cap_ff        <= cap_in;
         policy_ff     <= policy_in;
      end
   end

   assign ram_wr_en   = accept & wr_en;
   assign ram_wr_addr = wr_addr;
   assign ram_wr_data = DATA_WIDTH'(req_item.push_value);
   assign ram_rd_en   = accept & rd_en;
   assign ram_rd_addr = rd_addr;

   assign issue_info.status    = status;
   assign issue_info.pop_hit   = pop_hit;
   assign issue_info.drop_hit  = drop_hit;
   assign issue_info.occupancy = 5'(nx_cnt);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("item count above depth");

   a_enq_sticky: assert property (@(posedge clock) disable iff (reset)
      enq_closed_ff |=> enq_closed_ff)
      else $error("enqueue close flag cleared");

   a_deq_sticky: assert property (@(posedge clock) disable iff (reset)
      deq_closed_ff |=> deq_closed_ff)
      else $error("dequeue close flag cleared");

   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(cnt_ff) && $stable(front_ff))
      else $error("queue pointers moved without a transaction");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (accept && pop_hit) |-> (cnt_ff != '0) && !wr_en)
      else $error("pop issued on empty queue or with a write");

endmodule

// File: hw/rtl/bounded_deque_overflow_policy.sv
// Bounded double-ended queue of DATA_WIDTH-bit words held in a DEPTH-entry
// ring RAM. Each request transaction (push back, push front, pop back, pop
// front, shutdown) yields exactly one response transaction, in order.
// The accepting cycle decides, updates front pointer / count / close flags
// and issues the RAM access; the read stage then carries the RAM read data
// (popped or evicted word) into the response register, raising rsp_valid,
// once that register is empty or being taken. Sustained rate is one request
// per cycle as long as the response side keeps taking transactions; the
// single read-stage slot plus the response register set the back-pressure.
// The slot RAM is not cleared after reset (only held entries are ever read),
// so the block is ready right out of reset. CSRs: index 0 capacity_limit
// (0 acts as 1, above DEPTH acts as DEPTH), index 1 overflow_mode (wait, drop
// newest, drop oldest, fail).
// Write CSRs only while the queue has no transaction in flight.
module bounded_deque_overflow_policy #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bdop_pkg::req_item_type            req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bdop_pkg::rsp_item_type            rsp_data,
   // CSR write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bdop_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bdop_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                     accept;
   logic                     move;
   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
   logic [DATA_WIDTH-1:0]    ram_wr_data, ram_rd_data;
   logic [31:0]              rd_word;
   bdop_pkg::issue_info_type issue_info;

   // read stage: one transaction waiting for its RAM data
   logic                     pend_ff, pend_in;
   bdop_pkg::issue_info_type pend_info_ff, pend_info_in;
   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   bdop_pkg::rsp_item_type   rsp_data_ff, rsp_data_in;

   // CSR writes are always taken
   assign csr_ready = 1'b1;

   // read stage drains when the response register is empty or being taken
   assign move      = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || move;
   assign accept    = req_valid && req_ready;

   bdop_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_data),
      .csr_write   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .issue_info  (issue_info)
   );

   // read data only changes on a new read, so it holds while the stage stalls
   bdop_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_word = 32'(ram_rd_data);

   always_comb begin
      pend_in      = accept ? 1'b1 : (move ? 1'b0 : pend_ff);
      pend_info_in = accept ? issue_info : pend_info_ff;
      rsp_valid_in = move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (move) begin
         rsp_data_in.status     = pend_info_ff.status;
         rsp_data_in.pop_value  = pend_info_ff.pop_hit ? rd_word : '0;
         rsp_data_in.drop_valid = pend_info_ff.drop_hit;
         rsp_data_in.drop_value = pend_info_ff.drop_hit ? rd_word : '0;
         rsp_data_in.occupancy  = pend_info_ff.occupancy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_info_ff <= pend_info_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: dv/bounded_deque_overflow_policy_tb.sv
`timescale 1ns / 100ps

module bounded_deque_overflow_policy_tb;

   // Ring size of the instance under test (default DEPTH).
   localparam int SLOTS = 16;
   // Cycles with no transaction on any channel before the run is called hung.
   localparam int STALL_LIMIT = 2000;
   // Request codes the block does not decode; they must come back failed.
   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
   // Unmapped CSR indexes; writes there must not disturb anything.
   localparam logic [bdop_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [bdop_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   // Shutdown masks.
   localparam logic [1:0] CLOSE_NONE = 2'b00;
   localparam logic [1:0] CLOSE_ENQ  = 2'b01;
   localparam logic [1:0] CLOSE_DEQ  = 2'b10;
   localparam logic [1:0] CLOSE_BOTH = 2'b11;
   localparam int NUM_PHASES = 12;
   localparam int PHASE_ITEMS = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bdop_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bdop_pkg::rsp_item_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bdop_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bdop_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   bounded_deque_overflow_policy u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Shadow deque: the words the block should be holding, plus its CSRs
   // and close flags. Updated once per accepted request; CSRs per CSR write.
   // ------------------------------------------------------------------
   logic [31:0] deque_slots [SLOTS];
   logic [3:0]  head_idx   = '0;
   logic [4:0]  word_count = '0;
   logic        enq_shut   = 1'b0;
   logic        deq_shut   = 1'b0;
   logic [4:0]  cap_reg    = bdop_pkg::CAPACITY_RESET;
   logic [1:0]  policy_reg = bdop_pkg::POLICY_WAIT;

   bdop_pkg::req_item_type req_backlog [$];   // requests not yet presented
   bdop_pkg::rsp_item_type owed_rsps [$];     // responses still owed, oldest first
   int unsigned  reqs_posted = 0;
   int unsigned  reqs_taken  = 0;
   bit           req_taken_flag = 1'b0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int unsigned  fail_count = 0;
   int unsigned  quiet_cycles = 0;

   logic [4:0] phase_cap [NUM_PHASES];
   logic [1:0] phase_policy [NUM_PHASES];
   int         phase_push_pct [NUM_PHASES];

   function automatic logic [31:0] pull_back();
      logic [3:0] ix;
      ix = head_idx + word_count[3:0] - 4'd1;
      word_count = word_count - 5'd1;
      return deque_slots[ix];
   endfunction

   function automatic logic [31:0] pull_front();
      logic [31:0] w;
      w = deque_slots[head_idx];
      head_idx = head_idx + 4'd1;
      word_count = word_count - 5'd1;
      return w;
   endfunction

   // Apply one request to the shadow deque and return the response it earns.
   function automatic bdop_pkg::rsp_item_type deque_apply(bdop_pkg::req_item_type rq);
      bdop_pkg::rsp_item_type r;
      logic [4:0] lim;
      logic       to_back;
      logic       evict_back;
      logic       admit;
      logic [3:0] ix;
      r = '0;
      // capacity 0 behaves as 1, anything above the ring size as the ring size
      lim = (cap_reg == 5'd0) ? 5'd1 : ((cap_reg > 5'(SLOTS)) ? 5'(SLOTS) : cap_reg);
      case (rq.req_type)
         bdop_pkg::REQ_PUSH_BACK, bdop_pkg::REQ_PUSH_FRONT: begin
            to_back = (rq.req_type == bdop_pkg::REQ_PUSH_BACK);
            if (enq_shut) begin
               // closed wins over full
               r.status = bdop_pkg::STATUS_FAILED;
            end else begin
               admit = 1'b1;
               // count may sit above a freshly lowered limit: still full
               if (word_count >= lim) begin
                  if (policy_reg == bdop_pkg::POLICY_WAIT) begin
                     r.status = bdop_pkg::STATUS_WOULD_BLOCK;
                     admit = 1'b0;
                  end else if (policy_reg == bdop_pkg::POLICY_FAIL) begin
                     r.status = bdop_pkg::STATUS_FAILED;
                     admit = 1'b0;
                  end else begin
                     // newest end is the push's own end, oldest the other one
                     evict_back = (policy_reg == bdop_pkg::POLICY_DROP_NEWEST)
                                  ? to_back : !to_back;
                     r.drop_value = evict_back ? pull_back() : pull_front();
                     r.drop_valid = 1'b1;
                  end
               end
               if (admit) begin
                  if (to_back) begin
                     ix = head_idx + word_count[3:0];
                     deque_slots[ix] = rq.push_value;
                  end else begin
                     head_idx = head_idx - 4'd1;
                     deque_slots[head_idx] = rq.push_value;
                  end
                  word_count = word_count + 5'd1;
               end
            end
         end
         bdop_pkg::REQ_POP_BACK, bdop_pkg::REQ_POP_FRONT: begin
            // closed dequeue still drains what is held
            if (word_count == 5'd0)
               r.status = deq_shut ? bdop_pkg::STATUS_FAILED
                                   : bdop_pkg::STATUS_WOULD_BLOCK;
            else
               r.pop_value = (rq.req_type == bdop_pkg::REQ_POP_BACK) ? pull_back()
                                                                      : pull_front();
         end
         bdop_pkg::REQ_SHUTDOWN: begin
            if (rq.close_mask[0]) enq_shut = 1'b1;
            if (rq.close_mask[1]) deq_shut = 1'b1;
         end
         default: r.status = bdop_pkg::STATUS_FAILED;
      endcase
      r.occupancy = word_count;
      return r;
   endfunction

   function automatic bdop_pkg::req_item_type make_req(logic [2:0] kind, logic [31:0] word,
                                                       logic [1:0] mask);
      bdop_pkg::req_item_type rq;
      rq.req_type = kind;
      rq.push_value = word;
      rq.close_mask = mask;
      return rq;
   endfunction

   // Random request. push_pct steers the fill level; a few percent is noise
   // (spare codes, shutdowns). Shutdowns only close a side when allowed,
   // since closing is sticky for the rest of the run.
   function automatic bdop_pkg::req_item_type random_req(int push_pct, bit may_close);
      bdop_pkg::req_item_type rq;
      int roll;
      rq.push_value = $urandom;
      rq.close_mask = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         if ($urandom_range(0, 1)) begin
            rq.req_type = bdop_pkg::REQ_SHUTDOWN;
            if (!may_close) rq.close_mask = CLOSE_NONE;
         end else begin
            rq.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
         end
      end else if ($urandom_range(0, 99) < push_pct) begin
         rq.req_type = $urandom_range(0, 1) ? bdop_pkg::REQ_PUSH_BACK
                                            : bdop_pkg::REQ_PUSH_FRONT;
      end else begin
         rq.req_type = $urandom_range(0, 1) ? bdop_pkg::REQ_POP_BACK
                                            : bdop_pkg::REQ_POP_FRONT;
      end
      return rq;
   endfunction

   task automatic post_req(bdop_pkg::req_item_type rq);
      req_backlog.push_back(rq);
      reqs_posted++;
   endtask

   // Block until every posted request is taken and answered. Polled at the
   // falling edge so the rising-edge bookkeeping has settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (reqs_taken != reqs_posted || owed_rsps.size() != 0);
   endtask

   // One CSR write; only called with nothing in flight.
   task automatic csr_write(logic [bdop_pkg::CSR_INDEX_W-1:0] idx,
                            logic [bdop_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         bdop_pkg::CSR_CAPACITY_LIMIT: cap_reg = data;
         bdop_pkg::CSR_OVERFLOW_MODE:  policy_reg = data[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Driver: everything changes on the falling edge. A request stays up
   // with a stable payload until the rising-edge sampler marks it taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken_flag) begin
            req_taken_flag = 1'b0;
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: on the rising edge, predict each accepted request, then
   // check each accepted response against the oldest owed one. Also the
   // hang watchdog.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      bdop_pkg::rsp_item_type want;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            owed_rsps.push_back(deque_apply(req_data));
            reqs_taken++;
            req_taken_flag = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_rsps.size() == 0) begin
               $display("%0t: response with nothing outstanding: expected none, got %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = owed_rsps.pop_front();
               check_field("status",     32'(want.status),     32'(rsp_data.status));
               check_field("pop_value",  want.pop_value,        rsp_data.pop_value);
               check_field("drop_valid", 32'(want.drop_valid), 32'(rsp_data.drop_valid));
               check_field("drop_value", want.drop_value,       rsp_data.drop_value);
               check_field("occupancy",  32'(want.occupancy),  32'(rsp_data.occupancy));
            end
         end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      int p;
      int n;
      // Phase plan: capacity, policy, push bias. Ordered so a big fill is
      // followed by a small limit (count above capacity), and the limit
      // extremes 0, 1, 16, 17 and 31 all show up.
      phase_cap      = '{5'd16, 5'd5, 5'd2, 5'd0, 5'd31, 5'd3,
                         5'd1, 5'd8, 5'd17, 5'd4, 5'd12, 5'd6};
      phase_policy   = '{bdop_pkg::POLICY_WAIT,        bdop_pkg::POLICY_DROP_NEWEST,
                         bdop_pkg::POLICY_DROP_OLDEST, bdop_pkg::POLICY_FAIL,
                         bdop_pkg::POLICY_DROP_NEWEST, bdop_pkg::POLICY_DROP_OLDEST,
                         bdop_pkg::POLICY_WAIT,        bdop_pkg::POLICY_FAIL,
                         bdop_pkg::POLICY_DROP_OLDEST, bdop_pkg::POLICY_DROP_NEWEST,
                         bdop_pkg::POLICY_WAIT,        bdop_pkg::POLICY_DROP_OLDEST};
      phase_push_pct = '{80, 60, 50, 55, 75, 60, 50, 65, 85, 55, 35, 60};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty pops, data extremes at both ends, a no-op shutdown,
      // spare codes, then drain back to empty. Reset config (16, wait).
      send_idle_pct = 22;
      recv_idle_pct = 67;
      post_req(make_req(bdop_pkg::REQ_POP_BACK,   32'h0000_0000, CLOSE_BOTH));
      post_req(make_req(bdop_pkg::REQ_POP_FRONT,  32'hFFFF_FFFF, CLOSE_BOTH));
      post_req(make_req(bdop_pkg::REQ_PUSH_BACK,  32'h0000_0000, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_PUSH_BACK,  32'hA5A5_A5A5, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_PUSH_FRONT, 32'h5A5A_5A5A, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_POP_BACK,   32'h0000_0000, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_POP_FRONT,  32'h0000_0000, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_SHUTDOWN,   32'hFFFF_FFFF, CLOSE_NONE));
      for (n = REQ_SPARE_FIRST; n <= REQ_SPARE_LAST; n++)
         post_req(make_req(3'(n), 32'hFFFF_FFFF, CLOSE_BOTH));
      post_req(make_req(bdop_pkg::REQ_POP_FRONT,  32'h0000_0000, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_POP_BACK,   32'h0000_0000, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_POP_BACK,   32'h0000_0000, CLOSE_NONE));
      wait_drained();

      // Random phases. Idling: receiver-heavy gaps first, then swapped,
      // then none at all.
      for (p = 0; p < NUM_PHASES; p++) begin
         csr_write(bdop_pkg::CSR_CAPACITY_LIMIT, phase_cap[p]);
         // upper data bits are ignored for the policy register
         csr_write(bdop_pkg::CSR_OVERFLOW_MODE, {3'($urandom_range(0, 7)), phase_policy[p]});
         if (p == 1) begin
            csr_write(CSR_SPARE_LO, 5'($urandom));
            csr_write(CSR_SPARE_HI, 5'($urandom));
         end
         if (p < 4) begin
            send_idle_pct = 22;
            recv_idle_pct = 67;
         end else if (p < 8) begin
            send_idle_pct = 67;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < PHASE_ITEMS; n++)
            post_req(random_req(phase_push_pct[p], 1'b0));
         wait_drained();
      end

      // Closing sequence: empty out, refill to the limit, close dequeue and
      // show held words still come out, close enqueue on a full queue (must
      // fail even under a drop policy), then empty pops fail.
      csr_write(bdop_pkg::CSR_CAPACITY_LIMIT, 5'd4);
      csr_write(bdop_pkg::CSR_OVERFLOW_MODE, {3'd0, bdop_pkg::POLICY_DROP_OLDEST});
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (n = 0; n < SLOTS; n++)
         post_req(make_req(bdop_pkg::REQ_POP_FRONT, $urandom, 2'($urandom_range(0, 3))));
      for (n = 0; n < 4; n++)
         post_req(make_req(bdop_pkg::REQ_PUSH_BACK, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_SHUTDOWN, $urandom, CLOSE_DEQ));
      post_req(make_req(bdop_pkg::REQ_POP_FRONT, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_POP_BACK, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_PUSH_FRONT, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_PUSH_FRONT, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_SHUTDOWN, $urandom, CLOSE_ENQ));
      post_req(make_req(bdop_pkg::REQ_PUSH_BACK, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_PUSH_FRONT, $urandom, CLOSE_NONE));
      for (n = 0; n < 4; n++)
         post_req(make_req(n[0] ? bdop_pkg::REQ_POP_BACK : bdop_pkg::REQ_POP_FRONT,
                           $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_POP_BACK, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_POP_FRONT, $urandom, CLOSE_NONE));
      post_req(make_req(bdop_pkg::REQ_SHUTDOWN, $urandom, CLOSE_BOTH));
      for (n = 0; n < 30; n++)
         post_req(random_req(50, 1'b1));
      wait_drained();

      // trailing window to catch any response the block should not send
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
